>>> hw/rtl/drq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline-ordered release queue package
// Shared constants, codes and record types of the release queue.
// ----------------------------------------------------------------------------
package drq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_PROXIES = 16;
   localparam int PX_W        = 4;
   localparam int TIME_W      = 63;
   localparam int CLIENT_W    = 32;
   localparam int TAG_W       = 16;
   localparam int CFGV_W      = 20;
   localparam int REQ_DATA_W  = 248;
   localparam int RSP_DATA_W  = 312;

   typedef enum logic [1:0] {
      CMD_ARRIVE = 2'd0,
      CMD_VERIFY = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_REPORT  = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_IDLE    = 2'd2;
   localparam logic [1:0] KIND_REJECT  = 2'd3;

   localparam logic [2:0] REG_RECEIVER_ID  = 3'd0;
   localparam logic [2:0] REG_IGNORE_DL    = 3'd1;
   localparam logic [2:0] REG_SKIP_FWD     = 3'd2;
   localparam logic [2:0] REG_MEAS_INTERVAL = 3'd3;
   localparam logic [2:0] REG_MIN_CHECK    = 3'd4;

   typedef struct packed {
      logic [7:0]        receiver_id;
      logic              ignore_deadlines;
      logic              skip_forwarding;
      logic [CFGV_W-1:0] measure_interval_us;
      logic [CFGV_W-1:0] min_check_us;
   } cfg_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [TIME_W-1:0]   now_us;
      logic [TIME_W-1:0]   deadline_us;
      logic [TIME_W-1:0]   key_dl;
      logic [CLIENT_W-1:0] client_key;
      logic [TIME_W-1:0]   send_time_us;
      logic [PX_W-1:0]     proxy_slot;
      logic [TAG_W-1:0]    request_tag;
      logic                verified_ok;
      logic                late;
   } item_type;

   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [TIME_W-1:0]   dl;
      logic [CLIENT_W-1:0] cl;
      logic                late;
      logic [TIME_W-1:0]   kdl;
      logic [CLIENT_W-1:0] kcl;
      logic                ver;
   } cell_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [TAG_W-1:0]    out_tag;
      logic [TIME_W-1:0]   out_deadline_us;
      logic [CLIENT_W-1:0] out_client_id;
      logic                out_late;
      logic                send_to_replica;
      logic [TIME_W-1:0]   next_check_us;
      logic [63:0]         one_way_delay_us;
      logic [TIME_W-1:0]   echo_send_time_us;
      logic [7:0]          report_receiver_id;
   } result_type;

endpackage

>>> hw/rtl/drq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release queue front end
// Accepts request transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module drq_front (
   input  logic                            clock,
   input  logic                            reset,
   input  drq_pkg::cfg_type                cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [drq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,
   output drq_pkg::item_type               q_item,
   output logic                            q_valid,
   input  logic                            q_pop
);

   drq_pkg::item_type mem_ff [2];
   drq_pkg::item_type item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   always_comb begin
      item_in.cmd          = drq_pkg::cmd_type'(req_tuser);
      item_in.now_us       = req_tdata[62:0];
      item_in.deadline_us  = req_tdata[125:63];
      item_in.client_key   = req_tdata[157:126];
      item_in.send_time_us = req_tdata[220:158];
      item_in.proxy_slot   = req_tdata[224:221];
      item_in.request_tag  = req_tdata[240:225];
      item_in.verified_ok  = req_tdata[241];
      item_in.late         = req_tdata[62:0] > req_tdata[125:63];
      if ((drq_pkg::cmd_type'(req_tuser) == drq_pkg::CMD_ARRIVE) && cfg.ignore_deadlines) begin
         item_in.key_dl = req_tdata[62:0];
      end else begin
         item_in.key_dl = req_tdata[125:63];
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("Queue popped while empty.");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> cnt_ff == 2'd2)
      else $error("Full queue lost an entry.");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("Queue count overflow.");
`endif

endmodule

>>> hw/rtl/drq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release queue back end
// Sorted cell chain, per-proxy delay limiter and result sequencer.
// ----------------------------------------------------------------------------
module drq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  drq_pkg::cfg_type     cfg,
   input  drq_pkg::item_type    q_item,
   input  logic                 q_valid,
   output logic                 q_pop,
   output drq_pkg::result_type  rsp_res,
   output logic                 rsp_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready
);

   localparam int D = drq_pkg::QUEUE_DEPTH;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_LIM  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   drq_pkg::item_type   it_ff;
   drq_pkg::cell_type   cell_ff [D];
   drq_pkg::cell_type   cell_in [D];
   drq_pkg::cell_type   shift_dn [D];
   drq_pkg::cell_type   shift_up [D];
   drq_pkg::cell_type   newc;
   logic [D-1:0]        vld_ff, vld_in, lt, eq, prev_lt, vld_up;
   logic                hit, full, release_ok;
   logic [drq_pkg::TIME_W-1:0] lrt_ff [drq_pkg::NUM_PROXIES];
   logic [drq_pkg::TIME_W-1:0] lrt_rd_ff;
   drq_pkg::result_type res_ff [2];
   drq_pkg::result_type exec_res, lim_res;
   logic [1:0]          cnt_ff;
   logic                idx_ff;
   logic [63:0]         head_gap, lim_gap;
   logic                report;

   always_comb begin
      for (int i = 0; i < D; i++) begin
         lt[i] = vld_ff[i] && ({cell_ff[i].kdl, cell_ff[i].kcl} < {it_ff.key_dl, it_ff.client_key});
         eq[i] = vld_ff[i] && ({cell_ff[i].kdl, cell_ff[i].kcl} == {it_ff.key_dl, it_ff.client_key});
      end
      hit        = |eq;
      full       = vld_ff[D-1];
      release_ok = vld_ff[0] && cell_ff[0].ver;
      prev_lt    = {lt[D-2:0], 1'b1};
      vld_up     = {1'b0, vld_ff[D-1:1]};
      newc.tag   = it_ff.request_tag;
      newc.dl    = it_ff.deadline_us;
      newc.cl    = it_ff.client_key;
      newc.late  = it_ff.late;
      newc.kdl   = it_ff.key_dl;
      newc.kcl   = it_ff.client_key;
      newc.ver   = 1'b0;
      shift_dn[0]   = newc;
      shift_up[D-1] = cell_ff[D-1];
      for (int i = 1; i < D; i++) begin
         shift_dn[i]   = cell_ff[i-1];
         shift_up[i-1] = cell_ff[i];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      for (int i = 0; i < D; i++) begin
         cell_in[i] = cell_ff[i];
      end
      case (it_ff.cmd)
         drq_pkg::CMD_ARRIVE: begin
            if (hit) begin
               for (int i = 0; i < D; i++) begin
                  if (eq[i]) begin
                     cell_in[i].tag  = newc.tag;
                     cell_in[i].dl   = newc.dl;
                     cell_in[i].cl   = newc.cl;
                     cell_in[i].late = newc.late;
                     cell_in[i].ver  = 1'b0;
                  end
               end
            end else if (!full) begin
               vld_in = {vld_ff[D-2:0], 1'b1};
               for (int i = 0; i < D; i++) begin
                  if (!lt[i]) begin
                     cell_in[i] = prev_lt[i] ? newc : shift_dn[i];
                  end
               end
            end
         end
         drq_pkg::CMD_VERIFY: begin
            if (it_ff.verified_ok) begin
               for (int i = 0; i < D; i++) begin
                  if (eq[i]) begin
                     cell_in[i].ver = 1'b1;
                  end
               end
            end else if (hit) begin
               for (int i = 0; i < D; i++) begin
                  if (!lt[i]) begin
                     cell_in[i] = shift_up[i];
                     vld_in[i]  = vld_up[i];
                  end
               end
            end
         end
         drq_pkg::CMD_TICK: begin
            if (release_ok) begin
               vld_in = vld_up;
               for (int i = 0; i < D; i++) begin
                  cell_in[i] = shift_up[i];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      exec_res = '0;
      head_gap = {1'b0, cell_ff[1].kdl} - {1'b0, it_ff.now_us};
      if (it_ff.cmd == drq_pkg::CMD_ARRIVE) begin
         exec_res.result_kind     = drq_pkg::KIND_REJECT;
         exec_res.out_tag         = it_ff.request_tag;
         exec_res.out_deadline_us = it_ff.deadline_us;
         exec_res.out_client_id   = it_ff.client_key;
         exec_res.out_late        = it_ff.late;
      end else if (release_ok) begin
         exec_res.result_kind     = drq_pkg::KIND_RELEASE;
         exec_res.out_tag         = cell_ff[0].tag;
         exec_res.out_deadline_us = cell_ff[0].dl;
         exec_res.out_client_id   = cell_ff[0].cl;
         exec_res.out_late        = cell_ff[0].late;
         exec_res.send_to_replica = !cfg.skip_forwarding;
         if (vld_ff[1] && ($signed(head_gap) > $signed({44'd0, cfg.min_check_us}))) begin
            exec_res.next_check_us = head_gap[62:0];
         end else begin
            exec_res.next_check_us = {43'd0, cfg.min_check_us};
         end
      end else begin
         exec_res.result_kind   = drq_pkg::KIND_IDLE;
         exec_res.next_check_us = {43'd0, cfg.min_check_us};
      end
   end

   always_comb begin
      lim_res  = '0;
      lim_gap  = {1'b0, it_ff.now_us} - {1'b0, lrt_rd_ff};
      report   = $signed(lim_gap) > $signed({44'd0, cfg.measure_interval_us});
      lim_res.result_kind        = drq_pkg::KIND_REPORT;
      lim_res.one_way_delay_us   = {1'b0, it_ff.now_us} - {1'b0, it_ff.send_time_us};
      lim_res.echo_send_time_us  = it_ff.send_time_us;
      lim_res.report_receiver_id = cfg.receiver_id;
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (it_ff.cmd)
               drq_pkg::CMD_ARRIVE: state_in = ST_LIM;
               drq_pkg::CMD_TICK:   state_in = ST_OUT;
               default:             state_in = ST_IDLE;
            endcase
         end
         ST_LIM: begin
            state_in = (report || cnt_ff != 2'd0) ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready && rsp_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= '0;
         cnt_ff   <= 2'd0;
         idx_ff   <= 1'b0;
         for (int i = 0; i < drq_pkg::NUM_PROXIES; i++) begin
            lrt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= 2'd0;
               idx_ff <= 1'b0;
            end
            ST_EXEC: begin
               vld_ff <= vld_in;
               if ((it_ff.cmd == drq_pkg::CMD_TICK) ||
                   ((it_ff.cmd == drq_pkg::CMD_ARRIVE) && !hit && full)) begin
                  cnt_ff <= 2'd1;
               end
            end
            ST_LIM: begin
               if (report) begin
                  lrt_ff[it_ff.proxy_slot] <= it_ff.now_us;
                  cnt_ff                   <= cnt_ff + 2'd1;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  idx_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         it_ff <= q_item;
      end
      if (state_ff == ST_EXEC) begin
         for (int i = 0; i < D; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         lrt_rd_ff <= lrt_ff[it_ff.proxy_slot];
         res_ff[0] <= exec_res;
      end
      if (state_ff == ST_LIM && report) begin
         res_ff[cnt_ff[0]] <= lim_res;
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_res   = res_ff[idx_ff];
   assign rsp_last  = idx_ff || (cnt_ff == 2'd1);

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) (vld_ff & (vld_ff + 1'b1)) == '0)
      else $error("Valid cells do not form a prefix.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff == 2'd1 || cnt_ff == 2'd2))
      else $error("Result shown with no pending result.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && it_ff.cmd == drq_pkg::CMD_TICK) |=> rsp_valid)
      else $error("Tick produced no result.");
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && state_ff == ST_IDLE) |=> state_ff == ST_EXEC)
      else $error("Dequeued item not executed.");
`endif

endmodule

>>> hw/rtl/deadline_ordered_release_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline-ordered release queue
// Keeps requests sorted by (deadline or, if ignored, arrival time; client),
// releases verified heads on ticks and emits per-proxy one-way delay reports.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req_     in         tdata: now, deadline, client, send time, proxy, tag, ok;
//                     tuser: command
// rsp_     out        tdata: result fields; tuser: kind; tlast: final result
// csr_     in         write enable, register index, write data
//
// In the back end an item is dequeued, updates the cell chain and passes the
// limiter, in states set by its sequencer, before its results are delivered.
// Ticks and verifies skip the limiter. The front queue holds two items, so
// request transactions are still taken while results stall, until it fills.
// Reset is synchronous and clears the chain valid bits and limiter times.
// ----------------------------------------------------------------------------
module deadline_ordered_release_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_us, deadline_us, client_key, send_time_us, proxy_slot, request_tag,
   // verified_ok, zero pad
   input  logic [drq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_tag, out_deadline_us, out_client_id, out_late, send_to_replica,
   // next_check_us, one_way_delay_us, echo_send_time_us, report_receiver_id, pad
   output logic [drq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result_kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [drq_pkg::CFGV_W-1:0]      csr_wdata
);

   drq_pkg::cfg_type    cfg_ff;
   drq_pkg::item_type   q_item;
   logic                q_valid, q_pop;
   drq_pkg::result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.receiver_id         <= 8'd0;
         cfg_ff.ignore_deadlines    <= 1'b0;
         cfg_ff.skip_forwarding     <= 1'b0;
         cfg_ff.measure_interval_us <= 20'd5000;
         cfg_ff.min_check_us        <= 20'd1000;
      end else if (csr_we) begin
         case (csr_index)
            drq_pkg::REG_RECEIVER_ID:   cfg_ff.receiver_id         <= csr_wdata[7:0];
            drq_pkg::REG_IGNORE_DL:     cfg_ff.ignore_deadlines    <= csr_wdata[0];
            drq_pkg::REG_SKIP_FWD:      cfg_ff.skip_forwarding     <= csr_wdata[0];
            drq_pkg::REG_MEAS_INTERVAL: cfg_ff.measure_interval_us <= csr_wdata;
            drq_pkg::REG_MIN_CHECK:     cfg_ff.min_check_us        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   drq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   drq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp_res   (res),
      .rsp_last  (rsp_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tuser = res.result_kind;
   assign rsp_tdata = {1'b0, res.report_receiver_id, res.echo_send_time_us,
                       res.one_way_delay_us, res.next_check_us, res.send_to_replica,
                       res.out_late, res.out_client_id, res.out_deadline_us, res.out_tag};

endmodule

>>> tb/deadline_ordered_release_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline-ordered release queue testbench
// Drives arrivals, verify results, ticks and unused commands into the queue.
// The register settings change between phases, and both sides of the stream
// stall at random. A scoreboard predicts the sorted queue and the per-proxy
// delay limiter. It checks every result transaction field by field, in order.
// ----------------------------------------------------------------------------
import drq_pkg::*;

typedef struct {
   logic [15:0] tag;
   logic [62:0] dl;
   logic [31:0] cl;
   bit          late;
   logic [62:0] kdl;
   logic [31:0] kcl;
   bit          ver;
} slot_type;

typedef struct {
   logic [1:0]  kind;
   logic [15:0] tag;
   logic [62:0] dl;
   logic [31:0] cl;
   bit          late;
   bit          fwd;
   logic [62:0] next_chk;
   logic [63:0] owd;
   logic [62:0] echo;
   logic [7:0]  rid;
   bit          last;
} outcome_type;

class release_scoreboard;
   slot_type    slots[$];
   logic [62:0] last_report[NUM_PROXIES];
   outcome_type pending[$];
   logic [7:0]  receiver_id;
   bit          ignore_dl;
   bit          skip_fwd;
   logic [19:0] interval;
   logic [19:0] min_check;
   int          errors;
   int          n_checked;
   int          kind_seen[4];

   function new();
      foreach (last_report[i]) last_report[i] = '0;
      receiver_id = 0;
      ignore_dl = 0;
      skip_fwd = 0;
      interval = 5000;
      min_check = 1000;
   endfunction

   function void set_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
         REG_RECEIVER_ID:   receiver_id = val[7:0];
         REG_IGNORE_DL:     ignore_dl = val[0];
         REG_SKIP_FWD:      skip_fwd = val[0];
         REG_MEAS_INTERVAL: interval = val;
         REG_MIN_CHECK:     min_check = val;
         default: ;
      endcase
   endfunction

   function int find_pos(logic [62:0] d, logic [31:0] c);
      int p;
      p = 0;
      while (p < slots.size() && (slots[p].kdl < d || (slots[p].kdl == d && slots[p].kcl < c)))
         p++;
      return p;
   endfunction

   function bit key_at(int p, logic [62:0] d, logic [31:0] c);
      return p < slots.size() && slots[p].kdl == d && slots[p].kcl == c;
   endfunction

   function void note_item(cmd_type cmd, logic [62:0] now, logic [62:0] dl,
                           logic [31:0] cl, logic [62:0] st, logic [3:0] px,
                           logic [15:0] tag, bit ok);
      outcome_type o;
      slot_type    s;
      logic [62:0] kd;
      logic signed [63:0] gap, d, nc;
      int p, first;
      first = pending.size();
      o = '{default: '0};
      if (cmd == CMD_ARRIVE) begin
         kd = ignore_dl ? now : dl;
         p = find_pos(kd, cl);
         s = '{tag: tag, dl: dl, cl: cl, late: now > dl, kdl: kd, kcl: cl, ver: 0};
         if (key_at(p, kd, cl)) begin
            slots[p] = s;
         end else if (slots.size() >= QUEUE_DEPTH) begin
            o.kind = KIND_REJECT;
            o.tag = tag;
            o.dl = dl;
            o.cl = cl;
            o.late = s.late;
            pending.push_back(o);
         end else begin
            slots.insert(p, s);
         end
         gap = $signed({1'b0, now}) - $signed({1'b0, last_report[px]});
         if (gap > $signed({44'd0, interval})) begin
            last_report[px] = now;
            o = '{default: '0};
            o.kind = KIND_REPORT;
            o.owd = {1'b0, now} - {1'b0, st};
            o.echo = st;
            o.rid = receiver_id;
            pending.push_back(o);
         end
      end else if (cmd == CMD_VERIFY) begin
         p = find_pos(dl, cl);
         if (key_at(p, dl, cl)) begin
            if (ok) slots[p].ver = 1;
            else slots.delete(p);
         end
      end else if (cmd == CMD_TICK) begin
         if (slots.size() == 0 || !slots[0].ver) begin
            o.kind = KIND_IDLE;
            o.next_chk = min_check;
         end else begin
            o.kind = KIND_RELEASE;
            o.tag = slots[0].tag;
            o.dl = slots[0].dl;
            o.cl = slots[0].cl;
            o.late = slots[0].late;
            o.fwd = !skip_fwd;
            slots.delete(0);
            nc = {44'd0, min_check};
            if (slots.size() > 0) begin
               d = $signed({1'b0, slots[0].kdl}) - $signed({1'b0, now});
               if (d > nc) nc = d;
            end
            o.next_chk = nc[62:0];
         end
         pending.push_back(o);
      end
      if (pending.size() > first) pending[pending.size() - 1].last = 1;
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   task check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task check_result(outcome_type g);
      outcome_type w;
      if (pending.size() == 0) begin
         report_mismatch("unexpected result transaction", g.kind, 0);
         return;
      end
      w = pending.pop_front();
      n_checked++;
      kind_seen[w.kind]++;
      check_field("result_kind", g.kind, w.kind);
      check_field("out_tag", g.tag, w.tag);
      check_field("out_deadline_us", g.dl, w.dl);
      check_field("out_client_id", g.cl, w.cl);
      check_field("out_late", g.late, w.late);
      check_field("send_to_replica", g.fwd, w.fwd);
      check_field("next_check_us", g.next_chk, w.next_chk);
      check_field("one_way_delay_us", g.owd, w.owd);
      check_field("echo_send_time_us", g.echo, w.echo);
      check_field("report_receiver_id", g.rid, w.rid);
      check_field("last", g.last, w.last);
   endtask
endclass

module deadline_ordered_release_queue_tb;
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [2:0]            csr_index;
   logic [CFGV_W-1:0]     csr_wdata;

   release_scoreboard board;
   bit                calm;
   logic [62:0]       clock_us;
   int                n_sent;

   deadline_ordered_release_queue u_top (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver stalls come in random bursts until the calm tail of the run.
   initial begin
      int n;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.kind = rsp_tuser;
         g.tag = rsp_tdata[15:0];
         g.dl = rsp_tdata[78:16];
         g.cl = rsp_tdata[110:79];
         g.late = rsp_tdata[111];
         g.fwd = rsp_tdata[112];
         g.next_chk = rsp_tdata[175:113];
         g.owd = rsp_tdata[239:176];
         g.echo = rsp_tdata[302:240];
         g.rid = rsp_tdata[310:303];
         g.last = rsp_tlast;
         board.check_result(g);
      end
   end

   task send_item(cmd_type cmd, logic [62:0] now, logic [62:0] dl, logic [31:0] cl,
                  logic [62:0] st, logic [3:0] px, logic [15:0] tag, bit ok);
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {6'd0, ok, tag, px, st, cl, dl, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(cmd, now, dl, cl, st, px, tag, ok);
      n_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [19:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.set_reg(idx, val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   function logic [62:0] wide63();
      return {$urandom, $urandom};
   endfunction

   // Arrivals, verifies, ticks, unused commands; verifies favour queued keys.
   task random_item();
      int          r, p;
      logic [62:0] dl, st;
      logic [31:0] cl;
      if ($urandom_range(0, 2) != 0) clock_us = clock_us + $urandom_range(0, 400);
      r = $urandom_range(0, 99);
      cl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
      if (r < 45) begin
         dl = ($urandom_range(0, 19) == 0) ? wide63()
              : clock_us + $urandom_range(0, 3000) - 1000;
         st = ($urandom_range(0, 19) == 0) ? wide63() : clock_us - $urandom_range(0, 500);
         send_item(CMD_ARRIVE, clock_us, dl, cl, st, $urandom, $urandom, $urandom);
      end else if (r < 72) begin
         if (board.slots.size() > 0 && $urandom_range(0, 4) != 0) begin
            p = $urandom_range(0, board.slots.size() - 1);
            send_item(CMD_VERIFY, clock_us, board.slots[p].kdl, board.slots[p].kcl,
                      wide63(), $urandom, $urandom, $urandom_range(0, 5) != 0);
         end else begin
            send_item(CMD_VERIFY, clock_us, clock_us, cl, wide63(), $urandom, $urandom,
                      $urandom);
         end
      end else if (r < 96) begin
         send_item(CMD_TICK, clock_us, wide63(), $urandom, wide63(), $urandom, $urandom,
                   $urandom);
      end else begin
         send_item(CMD_NONE, wide63(), wide63(), $urandom, wide63(), $urandom, $urandom,
                   $urandom);
      end
   endtask

   initial begin
      logic [62:0] max63;
      int          i;
      board = new();
      max63 = '1;
      calm = 0;
      clock_us = 0;
      n_sent = 0;
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      req_tuser <= CMD_NONE;
      csr_we <= 0;
      csr_index <= REG_RECEIVER_ID;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed corner cases under the reset register values.
      send_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_ARRIVE, max63, 0, '1, max63, 4'hf, 16'hffff, 1);
      send_item(CMD_ARRIVE, 100, 5000, 0, 9000, 0, 16'h0001, 0);
      send_item(CMD_ARRIVE, 200, 5000, 0, 150, 0, 16'h0002, 0);
      send_item(CMD_ARRIVE, 7000, 5000, 3, 6000, 0, 16'h0003, 0);
      send_item(CMD_TICK, 7000, 0, 0, 0, 0, 0, 0);
      send_item(CMD_VERIFY, 7000, 5000, 9, 0, 0, 0, 1);
      send_item(CMD_VERIFY, 7000, 0, '1, 0, 0, 0, 1);
      send_item(CMD_TICK, 7000, 0, 0, 0, 0, 0, 0);
      send_item(CMD_VERIFY, 7000, 5000, 3, 0, 0, 0, 0);
      send_item(CMD_VERIFY, 7000, 5000, 0, 0, 0, 0, 1);
      send_item(CMD_TICK, 10, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NONE, max63, max63, '1, max63, 4'hf, 16'hffff, 1);
      send_item(CMD_TICK, 10, 0, 0, 0, 0, 0, 0);
      drain();

      // Extreme settings, then fill the queue past its depth to force rejections.
      write_reg(REG_RECEIVER_ID, 8'hff);
      write_reg(REG_IGNORE_DL, 1);
      write_reg(REG_SKIP_FWD, 1);
      write_reg(REG_MEAS_INTERVAL, 0);
      write_reg(REG_MIN_CHECK, 0);
      clock_us = 20000;
      for (i = 0; i < QUEUE_DEPTH + 6; i++)
         send_item(CMD_ARRIVE, clock_us + i, clock_us, i, clock_us, i, i, 0);
      send_item(CMD_ARRIVE, clock_us + 3, 0, 3, 0, 1, 16'haaaa, 0);
      for (i = 0; i < 8; i++) begin
         send_item(CMD_VERIFY, 0, clock_us + i, i, 0, 0, 0, 1);
         send_item(CMD_TICK, clock_us, 0, 0, 0, 0, 0, 0);
      end
      clock_us = clock_us + 100;
      for (i = 0; i < 100; i++) random_item();
      drain();

      write_reg(REG_RECEIVER_ID, 8'h00);
      write_reg(REG_IGNORE_DL, 0);
      write_reg(REG_MEAS_INTERVAL, 20'hfffff);
      write_reg(REG_MIN_CHECK, 20'hfffff);
      for (i = 0; i < 100; i++) random_item();
      drain();

      write_reg(REG_RECEIVER_ID, 20'($urandom_range(0, 255)));
      write_reg(REG_SKIP_FWD, 0);
      write_reg(REG_MEAS_INTERVAL, 300);
      write_reg(REG_MIN_CHECK, 50);
      for (i = 0; i < 100; i++) random_item();
      calm = 1;
      for (i = 0; i < 90; i++) random_item();
      drain();

      $display("Sent %0d request transactions, checked %0d results.", n_sent,
               board.n_checked);
      $display("Reports %0d, releases %0d, idle ticks %0d, rejections %0d.",
               board.kind_seen[KIND_REPORT], board.kind_seen[KIND_RELEASE],
               board.kind_seen[KIND_IDLE], board.kind_seen[KIND_REJECT]);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
hw/rtl/drq_pkg.sv
hw/rtl/drq_front.sv
hw/rtl/drq_back.sv
hw/rtl/deadline_ordered_release_queue.sv
tb/deadline_ordered_release_queue_tb.sv
